// File: src/gesture_template_matcher_defines.svh
// Assertion macros for the gesture template matcher.
`ifndef GESTURE_TEMPLATE_MATCHER_DEFINES_SVH
`define GESTURE_TEMPLATE_MATCHER_DEFINES_SVH

`ifndef SYNTH
`define GTM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gtm: same-cycle check failed");
`define GTM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gtm: next-cycle check failed");
`else
`define GTM_ASSERT_IMP(label, ante, cons)
`define GTM_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: src/gtm_pkg.sv
// Shared types, constants and helpers of the gesture template matcher.
package gtm_pkg;

	localparam int WINDOW_DEF       = 3;
	localparam int TEMPLATE_LEN_DEF = 8;
	localparam int GESTURES_DEF     = 3;

	localparam int AXIS_W   = 16;
	localparam int THR_W    = 15;
	localparam int NAXES    = 5;
	localparam int NACC     = 2;
	localparam int NSYMBOLS = 3;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [1:0] REG_ENABLE    = 2'd0;
	localparam logic [1:0] REG_ACCEL_THR = 2'd1;
	localparam logic [1:0] REG_GYRO_THR  = 2'd2;

	localparam logic [THR_W-1:0] ACCEL_THR_RESET = 15'd1843;
	localparam logic [THR_W-1:0] GYRO_THR_RESET  = 15'd2400;

	typedef struct packed {
		logic                     operation;
		logic [1:0]               gesture;
		logic [2:0]               position;
		logic signed [AXIS_W-1:0] accel_x;
		logic signed [AXIS_W-1:0] accel_y;
		logic signed [AXIS_W-1:0] gyro_x;
		logic signed [AXIS_W-1:0] gyro_y;
		logic signed [AXIS_W-1:0] gyro_z;
	} in_item_t;

	typedef struct packed {
		logic       symbol_valid;
		logic [1:0] symbol_code;
		logic       any_match;
	} out_item_t;

	// axes 0..NACC-1 are acceleration, the rest rotation rate
	typedef logic [NAXES-1:0][AXIS_W-1:0] sample_t;

	typedef struct packed {
		logic go;
		logic live;
	} match_ctl_t;

	typedef struct packed {
		logic      idle;
		logic      done;
		out_item_t item;
	} match_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GES,
		ST_READ,
		ST_DRAIN,
		ST_DIFF,
		ST_CMP,
		ST_FIN
	} gtm_state_t;

	function automatic int sum_width(int window);
		return AXIS_W + $clog2(window);
	endfunction

endpackage

// File: src/gtm_tmpl_mem.sv
// Template sample store: one write port, one registered read port.
module gtm_tmpl_mem #(
	parameter int GESTURES     = gtm_pkg::GESTURES_DEF,
	parameter int TEMPLATE_LEN = gtm_pkg::TEMPLATE_LEN_DEF,
	localparam int DEPTH       = GESTURES * TEMPLATE_LEN,
	localparam int ADDR_W      = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  gtm_pkg::sample_t    wr_data,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr,
	output gtm_pkg::sample_t    rd_data
);

	gtm_pkg::sample_t mem_q [DEPTH];
	gtm_pkg::sample_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/gtm_window.sv
// Live sample window with running per-axis sums.
module gtm_window #(
	parameter int WINDOW = gtm_pkg::WINDOW_DEF,
	localparam int SUM_W = gtm_pkg::sum_width(WINDOW)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  shift,
	input  gtm_pkg::sample_t                      sample,
	output logic [gtm_pkg::NAXES-1:0][SUM_W-1:0]  sums
);

	gtm_pkg::sample_t                      win_q [WINDOW];
	logic [gtm_pkg::NAXES-1:0][SUM_W-1:0]  sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WINDOW; k++) begin
				win_q[k] <= '0;
			end
			sum_q <= '0;
		end else if (shift) begin
			for (int k = 0; k < WINDOW - 1; k++) begin
				win_q[k] <= win_q[k + 1];
			end
			win_q[WINDOW - 1] <= sample;
			// add the new sample, drop the oldest
			for (int j = 0; j < gtm_pkg::NAXES; j++) begin
				sum_q[j] <= sum_q[j] + SUM_W'($signed(sample[j]))
					- SUM_W'($signed(win_q[0][j]));
			end
		end
	end

	assign sums = sum_q;

endmodule

// File: src/gtm_match.sv
// Match sequencer: template run sums, threshold compare, progress counts.
module gtm_match #(
	parameter int WINDOW       = gtm_pkg::WINDOW_DEF,
	parameter int TEMPLATE_LEN = gtm_pkg::TEMPLATE_LEN_DEF,
	parameter int GESTURES     = gtm_pkg::GESTURES_DEF,
	localparam int SUM_W       = gtm_pkg::sum_width(WINDOW),
	localparam int ADDR_W      = $clog2(GESTURES * TEMPLATE_LEN)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  gtm_pkg::match_ctl_t                   ctl,
	input  logic [gtm_pkg::THR_W-1:0]             accel_thr,
	input  logic [gtm_pkg::THR_W-1:0]             gyro_thr,
	input  logic [gtm_pkg::NAXES-1:0][SUM_W-1:0]  sums,
	input  logic                                  out_free,
	output logic                                  rd_en,
	output logic [ADDR_W-1:0]                     rd_addr,
	input  gtm_pkg::sample_t                      rd_data,
	output gtm_pkg::match_status_t                status
);

	localparam int DIF_W = SUM_W + 2;
	localparam int CNT_W = $clog2(TEMPLATE_LEN + 1);
	localparam int CMP_W = $clog2(TEMPLATE_LEN + WINDOW + 1);
	localparam int GES_W = (GESTURES > 1) ? $clog2(GESTURES) : 1;
	localparam int K_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [K_W-1:0]   K_LAST = K_W'(WINDOW - 1);
	localparam logic [GES_W-1:0] G_LAST = GES_W'(GESTURES - 1);

	gtm_pkg::gtm_state_t state_q, state_d;

	logic [GES_W-1:0]  g_q;
	logic [ADDR_W-1:0] base_q;
	logic [K_W-1:0]    k_q;
	logic              rd_pend_s1;
	logic              any_q;
	logic              active_q;
	logic [CNT_W-1:0]  prog_q [GESTURES];

	logic [SUM_W-1:0]        tsum_q [gtm_pkg::NAXES];
	logic signed [DIF_W-1:0] diff_q [gtm_pkg::NAXES];
	logic signed [DIF_W-1:0] lim_acc_q;
	logic signed [DIF_W-1:0] lim_gyr_q;

	logic [CNT_W-1:0]          cur_prog;
	logic                      skip;
	logic                      over;
	logic                      last_g;
	logic                      advance;
	logic                      any_prog;
	logic [GESTURES-1:0]       past;
	logic                      found;
	logic [GES_W-1:0]          fidx;
	logic [gtm_pkg::NAXES-1:0] within_lim;
	logic                      hit;
	gtm_pkg::out_item_t        res_item;

	assign cur_prog = prog_q[g_q];
	assign skip     = active_q && (cur_prog == '0);
	assign over     = (CMP_W'(cur_prog) + CMP_W'(WINDOW)) > CMP_W'(TEMPLATE_LEN);
	assign last_g   = (g_q == G_LAST);

	always_comb begin
		any_prog = 1'b0;
		for (int g = 0; g < GESTURES; g++) begin
			any_prog = any_prog || (prog_q[g] != '0);
			past[g]  = (CMP_W'(prog_q[g]) + CMP_W'(WINDOW)) > CMP_W'(TEMPLATE_LEN);
		end
	end

	always_comb begin
		found = 1'b0;
		fidx  = '0;
		for (int g = GESTURES - 1; g >= 0; g--) begin
			if (past[g]) begin
				found = 1'b1;
				fidx  = GES_W'(g);
			end
		end
	end

	always_comb begin
		for (int j = 0; j < gtm_pkg::NAXES; j++) begin
			if (j < gtm_pkg::NACC) begin
				within_lim[j] = (diff_q[j] < lim_acc_q) && (diff_q[j] > -lim_acc_q);
			end else begin
				within_lim[j] = (diff_q[j] < lim_gyr_q) && (diff_q[j] > -lim_gyr_q);
			end
		end
	end

	assign hit = &within_lim;

	always_comb begin
		state_d = state_q;
		case (state_q)
			gtm_pkg::ST_IDLE: begin
				if (ctl.go) begin
					state_d = ctl.live ? gtm_pkg::ST_GES : gtm_pkg::ST_FIN;
				end
			end
			gtm_pkg::ST_GES: begin
				if (skip || over) begin
					state_d = last_g ? gtm_pkg::ST_FIN : gtm_pkg::ST_GES;
				end else begin
					state_d = gtm_pkg::ST_READ;
				end
			end
			gtm_pkg::ST_READ: begin
				if (k_q == K_LAST) begin
					state_d = gtm_pkg::ST_DRAIN;
				end
			end
			gtm_pkg::ST_DRAIN: state_d = gtm_pkg::ST_DIFF;
			gtm_pkg::ST_DIFF:  state_d = gtm_pkg::ST_CMP;
			gtm_pkg::ST_CMP:   state_d = last_g ? gtm_pkg::ST_FIN : gtm_pkg::ST_GES;
			gtm_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = gtm_pkg::ST_IDLE;
				end
			end
			default: state_d = gtm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en   = (state_q == gtm_pkg::ST_READ);
		rd_addr = base_q + ADDR_W'(cur_prog) + ADDR_W'(k_q);
		advance = (((state_q == gtm_pkg::ST_GES) && (skip || over))
			|| (state_q == gtm_pkg::ST_CMP)) && !last_g;
		res_item.symbol_valid = any_q && found && (int'(fidx) < gtm_pkg::NSYMBOLS);
		res_item.symbol_code  = res_item.symbol_valid ? 2'(fidx) : 2'd0;
		res_item.any_match    = any_q;
		status.idle = (state_q == gtm_pkg::ST_IDLE);
		status.done = (state_q == gtm_pkg::ST_FIN) && out_free;
		status.item = res_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= gtm_pkg::ST_IDLE;
			g_q        <= '0;
			base_q     <= '0;
			k_q        <= '0;
			rd_pend_s1 <= 1'b0;
			any_q      <= 1'b0;
			active_q   <= 1'b0;
			for (int g = 0; g < GESTURES; g++) begin
				prog_q[g] <= '0;
			end
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= rd_en;
			if ((state_q == gtm_pkg::ST_IDLE) && ctl.go) begin
				g_q      <= '0;
				base_q   <= '0;
				any_q    <= 1'b0;
				active_q <= any_prog;
			end
			if (state_q == gtm_pkg::ST_GES) begin
				k_q <= '0;
			end
			if (state_q == gtm_pkg::ST_READ) begin
				k_q <= k_q + K_W'(1);
			end
			if (advance) begin
				g_q    <= g_q + GES_W'(1);
				base_q <= base_q + ADDR_W'(TEMPLATE_LEN);
			end
			if ((state_q == gtm_pkg::ST_GES) && (skip || over)) begin
				prog_q[g_q] <= '0;
			end else if (state_q == gtm_pkg::ST_CMP) begin
				prog_q[g_q] <= hit ? cur_prog + CNT_W'(1) : '0;
				any_q       <= any_q || hit;
			end else if (status.done && any_q && found) begin
				for (int g = 0; g < GESTURES; g++) begin
					prog_q[g] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == gtm_pkg::ST_GES) begin
			for (int j = 0; j < gtm_pkg::NAXES; j++) begin
				tsum_q[j] <= '0;
			end
		end else if (rd_pend_s1) begin
			for (int j = 0; j < gtm_pkg::NAXES; j++) begin
				tsum_q[j] <= tsum_q[j] + SUM_W'($signed(rd_data[j]));
			end
		end
		if (state_q == gtm_pkg::ST_DIFF) begin
			for (int j = 0; j < gtm_pkg::NAXES; j++) begin
				diff_q[j] <= DIF_W'($signed(sums[j])) - DIF_W'($signed(tsum_q[j]));
			end
			lim_acc_q <= $signed(DIF_W'(WINDOW) * DIF_W'(accel_thr));
			lim_gyr_q <= $signed(DIF_W'(WINDOW) * DIF_W'(gyro_thr));
		end
	end

endmodule

// File: src/gesture_template_matcher.sv
// Top level of the gesture template matcher: ports, registers, result stage.
// A load item or a sample taken while disabled goes from idle straight to the finish
// state. A live sample visits each gesture in turn: a gesture that is skipped, or whose
// template run would pass the end, is left at once; any other gets WINDOW reads through
// the single read port of the template memory, then drain, difference and compare.
// in_stall is high while the sequencer works on an item; the result waits in an output
// register, so a new item is taken as soon as the sequencer is free. The template memory
// has no reset and needs no clearing pass; every entry that a live sample can reach must
// be loaded before use.
`include "gesture_template_matcher_defines.svh"

module gesture_template_matcher #(
	parameter int WINDOW       = gtm_pkg::WINDOW_DEF,
	parameter int TEMPLATE_LEN = gtm_pkg::TEMPLATE_LEN_DEF,
	parameter int GESTURES     = gtm_pkg::GESTURES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  gtm_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output gtm_pkg::out_item_t         out_data,
	input  logic                       cfg_wr_en,
	input  logic [1:0]                 cfg_index,
	input  logic [gtm_pkg::THR_W-1:0]  cfg_wdata
);

	localparam int SUM_W  = gtm_pkg::sum_width(WINDOW);
	localparam int ADDR_W = $clog2(GESTURES * TEMPLATE_LEN);

	logic                       enable_q;
	logic [gtm_pkg::THR_W-1:0]  accel_thr_q;
	logic [gtm_pkg::THR_W-1:0]  gyro_thr_q;
	logic                       out_valid_q;
	gtm_pkg::out_item_t         out_q;

	logic                                  accept;
	logic                                  out_free;
	gtm_pkg::sample_t                      in_sample;
	gtm_pkg::match_ctl_t                   m_ctl;
	gtm_pkg::match_status_t                m_status;
	logic [gtm_pkg::NAXES-1:0][SUM_W-1:0]  sums;
	logic                                  tm_wr_en;
	logic [ADDR_W-1:0]                     tm_wr_addr;
	logic                                  tm_rd_en;
	logic [ADDR_W-1:0]                     tm_rd_addr;
	gtm_pkg::sample_t                      tm_rd_data;

	assign in_stall  = !m_status.idle;
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_sample = {in_data.gyro_z, in_data.gyro_y, in_data.gyro_x,
		in_data.accel_y, in_data.accel_x};

	assign m_ctl.go   = accept;
	assign m_ctl.live = (in_data.operation == gtm_pkg::OP_SAMPLE) && enable_q;

	assign tm_wr_en = accept && (in_data.operation == gtm_pkg::OP_LOAD)
		&& (int'(in_data.gesture) < GESTURES) && (int'(in_data.position) < TEMPLATE_LEN);
	assign tm_wr_addr = ADDR_W'(ADDR_W'(in_data.gesture) * ADDR_W'(TEMPLATE_LEN))
		+ ADDR_W'(in_data.position);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			accel_thr_q <= gtm_pkg::ACCEL_THR_RESET;
			gyro_thr_q  <= gtm_pkg::GYRO_THR_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				gtm_pkg::REG_ENABLE:    enable_q    <= cfg_wdata[0];
				gtm_pkg::REG_ACCEL_THR: accel_thr_q <= cfg_wdata;
				gtm_pkg::REG_GYRO_THR:  gyro_thr_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (m_status.done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (m_status.done) begin
			out_q <= m_status.item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	gtm_window #(
		.WINDOW (WINDOW)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (accept && m_ctl.live),
		.sample (in_sample),
		.sums   (sums)
	);

	gtm_tmpl_mem #(
		.GESTURES     (GESTURES),
		.TEMPLATE_LEN (TEMPLATE_LEN)
	) u_tmpl_mem (
		.clk     (clk),
		.wr_en   (tm_wr_en),
		.wr_addr (tm_wr_addr),
		.wr_data (in_sample),
		.rd_en   (tm_rd_en),
		.rd_addr (tm_rd_addr),
		.rd_data (tm_rd_data)
	);

	gtm_match #(
		.WINDOW       (WINDOW),
		.TEMPLATE_LEN (TEMPLATE_LEN),
		.GESTURES     (GESTURES)
	) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (m_ctl),
		.accel_thr (accel_thr_q),
		.gyro_thr  (gyro_thr_q),
		.sums      (sums),
		.out_free  (out_free),
		.rd_en     (tm_rd_en),
		.rd_addr   (tm_rd_addr),
		.rd_data   (tm_rd_data),
		.status    (m_status)
	);

	`GTM_ASSERT_NXT(a_accept_leaves_idle, accept, !m_status.idle)
	`GTM_ASSERT_IMP(a_load_only_when_idle, tm_wr_en, m_status.idle && !tm_rd_en)
	`GTM_ASSERT_IMP(a_symbol_needs_match, out_valid_q && out_q.symbol_valid, out_q.any_match)

endmodule

// File: verif/gesture_template_matcher_test.sv
// Self-checking testbench of the gesture template matcher with its own symbol predictor.
module gesture_template_matcher_test;
	import gtm_pkg::*;

	localparam int SLOTS = GESTURES_DEF * TEMPLATE_LEN_DEF;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      cfg_wr_en;
	logic [1:0] cfg_index;
	logic [THR_W-1:0] cfg_wdata;

	// predictor state
	logic live_enable;
	int   accel_limit;
	int   gyro_limit;
	int   window_axes[WINDOW_DEF][NAXES];
	int   template_axes[SLOTS][NAXES];
	int   progress[GESTURES_DEF];

	out_item_t pending_symbols[$];
	out_item_t due;
	int mismatches;
	int useful_items;
	int matched_samples;
	int symbol_tally[NSYMBOLS];
	int sender_idle_pct;
	int stall_pct;
	int hold_left;

	gesture_template_matcher DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	initial begin
		#3_000_000;
		$display("[gesture_template_matcher] ERROR");
		$finish;
	end

	function automatic out_item_t predict_symbol(in_item_t it);
		out_item_t r;
		int ax[NAXES];
		int wsum[NAXES];
		int tsum;
		int d;
		int start;
		int slot;
		bit busy;
		bit hit;
		bit ok;
		r = '0;
		ax[0] = it.accel_x;
		ax[1] = it.accel_y;
		ax[2] = it.gyro_x;
		ax[3] = it.gyro_y;
		ax[4] = it.gyro_z;
		if (it.operation == OP_LOAD) begin
			if (it.gesture < GESTURES_DEF && it.position < TEMPLATE_LEN_DEF) begin
				slot = int'(it.gesture) * TEMPLATE_LEN_DEF + int'(it.position);
				template_axes[slot] = ax;
			end
			return r;
		end
		if (!live_enable)
			return r;
		for (int k = 0; k + 1 < WINDOW_DEF; k++)
			window_axes[k] = window_axes[k + 1];
		window_axes[WINDOW_DEF - 1] = ax;
		for (int a = 0; a < NAXES; a++) begin
			wsum[a] = 0;
			for (int k = 0; k < WINDOW_DEF; k++)
				wsum[a] += window_axes[k][a];
		end
		busy = 0;
		for (int g = 0; g < GESTURES_DEF; g++)
			if (progress[g] != 0)
				busy = 1;
		hit = 0;
		for (int g = 0; g < GESTURES_DEF; g++) begin
			if (busy && progress[g] == 0)
				continue;
			start = progress[g];
			ok = (start + WINDOW_DEF <= TEMPLATE_LEN_DEF);
			for (int a = 0; a < NAXES && ok; a++) begin
				tsum = 0;
				for (int k = 0; k < WINDOW_DEF; k++)
					tsum += template_axes[g * TEMPLATE_LEN_DEF + start + k][a];
				d = wsum[a] - tsum;
				if (d < 0)
					d = -d;
				if (d >= WINDOW_DEF * (a < NACC ? accel_limit : gyro_limit))
					ok = 0;
			end
			if (ok) begin
				progress[g]++;
				hit = 1;
			end else begin
				progress[g] = 0;
			end
		end
		if (hit) begin
			for (int g = 0; g < GESTURES_DEF; g++) begin
				if (progress[g] + WINDOW_DEF > TEMPLATE_LEN_DEF) begin
					if (g < NSYMBOLS) begin
						r.symbol_valid = 1'b1;
						r.symbol_code = 2'(g);
					end
					for (int h = 0; h < GESTURES_DEF; h++)
						progress[h] = 0;
					break;
				end
			end
		end
		r.any_match = hit;
		return r;
	endfunction

	function automatic in_item_t pack_axes(logic op, int g, int p, int ax[NAXES]);
		in_item_t it;
		it.operation = op;
		it.gesture = 2'(g);
		it.position = 3'(p);
		it.accel_x = 16'(ax[0]);
		it.accel_y = 16'(ax[1]);
		it.gyro_x = 16'(ax[2]);
		it.gyro_y = 16'(ax[3]);
		it.gyro_z = 16'(ax[4]);
		return it;
	endfunction

	function automatic in_item_t flat_item(logic op, int g, int p, int v);
		int ax[NAXES];
		foreach (ax[a])
			ax[a] = v;
		return pack_axes(op, g, p, ax);
	endfunction

	function automatic int moderate_axis();
		return int'($urandom_range(8191)) - 4096;
	endfunction

	function automatic int rand_axis();
		case ($urandom_range(9))
			0: return 32767;
			1: return -32768;
			2, 3: return moderate_axis();
			default: return int'($signed(16'($urandom)));
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_symbols.size() == 0) begin
				report_mismatch("result with no item pending");
			end else begin
				due = pending_symbols.pop_front();
				if (out_data.symbol_valid !== due.symbol_valid)
					report_mismatch($sformatf("symbol_valid got %b want %b",
						out_data.symbol_valid, due.symbol_valid));
				if (out_data.symbol_code !== due.symbol_code)
					report_mismatch($sformatf("symbol_code got %0d want %0d",
						out_data.symbol_code, due.symbol_code));
				if (out_data.any_match !== due.any_match)
					report_mismatch($sformatf("any_match got %b want %b",
						out_data.any_match, due.any_match));
				if (due.any_match)
					matched_samples++;
				if (due.symbol_valid && due.symbol_code < NSYMBOLS)
					symbol_tally[due.symbol_code]++;
			end
		end
	end

	// output side: long hold-off first, random stall otherwise
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_item(in_item_t item);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do
			@(posedge clk);
		while (in_stall);
		if ((item.operation == OP_LOAD && item.gesture < GESTURES_DEF) ||
			(item.operation == OP_SAMPLE && live_enable))
			useful_items++;
		pending_symbols.push_back(predict_symbol(item));
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_symbols.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, int val);
		wait_for_results();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[THR_W-1:0];
		@(posedge clk);
		case (idx)
			REG_ENABLE: live_enable = val[0];
			REG_ACCEL_THR: accel_limit = val & 32'h7FFF;
			REG_GYRO_THR: gyro_limit = val & 32'h7FFF;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_thresholds(int accel, int gyro);
		write_register(REG_ACCEL_THR, accel);
		write_register(REG_GYRO_THR, gyro);
	endtask

	task automatic send_noise_sample();
		int ax[NAXES];
		foreach (ax[a])
			ax[a] = rand_axis();
		send_item(pack_axes(OP_SAMPLE, $urandom_range(3), $urandom_range(7), ax));
	endtask

	// replay one gesture's template with noise scaled in quarters of the threshold
	task automatic send_gesture_run(int g, bit broken, int scale);
		int ax[NAXES];
		int stop;
		int glitch;
		int amp;
		int v;
		stop = broken ? $urandom_range(7, 2) : TEMPLATE_LEN_DEF;
		glitch = (broken && $urandom_range(1)) ? $urandom_range(stop - 1) : -1;
		for (int p = 0; p < stop; p++) begin
			if (p == glitch)
				send_noise_sample();
			for (int a = 0; a < NAXES; a++) begin
				amp = (a < NACC ? accel_limit : gyro_limit) * scale / 4;
				v = template_axes[g * TEMPLATE_LEN_DEF + p][a] +
					int'($urandom_range(2 * amp)) - amp;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				ax[a] = v;
			end
			send_item(pack_axes(OP_SAMPLE, $urandom_range(3), $urandom_range(7), ax));
		end
	endtask

	task automatic run_traffic(int count);
		int start;
		int roll;
		int ax[NAXES];
		bit wide;
		start = useful_items;
		while (useful_items - start < count) begin
			roll = $urandom_range(99);
			if (roll < 60) begin
				send_gesture_run($urandom_range(GESTURES_DEF - 1), $urandom_range(99) < 25,
					$urandom_range(3) == 0 ? 8 : $urandom_range(2));
			end else if (roll < 75) begin
				wide = $urandom_range(1);
				foreach (ax[a])
					ax[a] = wide ? rand_axis() : moderate_axis();
				send_item(pack_axes(OP_LOAD, $urandom_range(3), $urandom_range(7), ax));
			end else begin
				send_noise_sample();
			end
		end
	endtask

	task automatic test_template_fill();
		int ax[NAXES];
		for (int s = 0; s < SLOTS; s++) begin
			foreach (ax[a])
				ax[a] = moderate_axis();
			send_item(pack_axes(OP_LOAD, s / TEMPLATE_LEN_DEF, s % TEMPLATE_LEN_DEF, ax));
		end
	endtask

	task automatic test_disabled_samples();
		send_item(flat_item(OP_SAMPLE, 3, 7, 32767));
		send_item(flat_item(OP_SAMPLE, 0, 0, -32768));
		send_noise_sample();
	endtask

	task automatic test_field_extremes();
		write_register(REG_ENABLE, 1);
		send_item(flat_item(OP_LOAD, 3, 0, -32768));
		send_item(flat_item(OP_LOAD, 3, 7, 32767));
		send_item(flat_item(OP_SAMPLE, 3, 7, 32767));
		send_item(flat_item(OP_SAMPLE, 0, 0, -32768));
	endtask

	task automatic test_priority_all_match();
		int ax[NAXES];
		set_thresholds(32767, 32767);
		repeat (8) begin
			foreach (ax[a])
				ax[a] = moderate_axis();
			send_item(pack_axes(OP_SAMPLE, 0, 0, ax));
		end
	endtask

	task automatic test_zero_threshold();
		set_thresholds(0, 0);
		send_gesture_run(0, 1'b1, 0);
	endtask

	task automatic test_space_sequence();
		set_thresholds(ACCEL_THR_RESET, GYRO_THR_RESET);
		send_gesture_run(2, 1'b0, 0);
	endtask

	task automatic test_backpressure();
		wait_for_results();
		sender_idle_pct = 0;
		stall_pct = 0;
		hold_left = 400;
		run_traffic(30);
		wait_for_results();
		run_traffic(10);
	endtask

	task automatic test_random_traffic();
		sender_idle_pct = 0;
		stall_pct = 0;
		set_thresholds(ACCEL_THR_RESET, GYRO_THR_RESET);
		run_traffic(150);
		sender_idle_pct = 77;
		set_thresholds($urandom_range(4000), $urandom_range(4000));
		run_traffic(150);
		sender_idle_pct = 0;
		stall_pct = 77;
		set_thresholds(40, 60);
		run_traffic(150);
		sender_idle_pct = 8;
		stall_pct = 8;
		set_thresholds(32767, 32767);
		run_traffic(100);
		write_register(REG_ENABLE, 0);
		repeat (20)
			send_noise_sample();
		write_register(REG_ENABLE, 1);
		set_thresholds($urandom_range(32767), $urandom_range(3000));
		run_traffic(120);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_wdata = '0;
		live_enable = 1'b0;
		accel_limit = ACCEL_THR_RESET;
		gyro_limit = GYRO_THR_RESET;
		foreach (window_axes[k, a])
			window_axes[k][a] = 0;
		foreach (template_axes[s, a])
			template_axes[s][a] = 0;
		foreach (progress[g])
			progress[g] = 0;
		foreach (symbol_tally[c])
			symbol_tally[c] = 0;
		mismatches = 0;
		useful_items = 0;
		matched_samples = 0;
		sender_idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_template_fill();
		test_disabled_samples();
		test_field_extremes();
		test_priority_all_match();
		test_zero_threshold();
		test_space_sequence();
		test_backpressure();
		test_random_traffic();

		wait_for_results();
		repeat (50)
			@(posedge clk);
		$display("covered %0d loads and live samples, %0d matching samples",
			useful_items, matched_samples);
		$display("symbols dot %0d dash %0d space %0d; thresholds 0..32767, idle and hold-off",
			symbol_tally[0], symbol_tally[1], symbol_tally[2]);
		if (mismatches == 0) begin
			$display("[gesture_template_matcher] OK");
		end else begin
			$display("[gesture_template_matcher] ERROR");
		end
		$finish;
	end
endmodule

// File: gesture_template_matcher.f
+incdir+src
src/gtm_pkg.sv
src/gtm_tmpl_mem.sv
src/gtm_window.sv
src/gtm_match.sv
src/gesture_template_matcher.sv
verif/gesture_template_matcher_test.sv
